### hdl/dpf_pkg.sv
// ============================================================================
// dpf_pkg
// Shared types and constants of the duplicate packet filter.
// ============================================================================
package dpf_pkg;

   localparam int ENTRIES = 32;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam int ADDR_W  = 48;
   localparam int SEQ_W   = 16;
   localparam int TIME_W  = 48;
   localparam int TTL_W   = 26;

   localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(5 * 1000 * 1000);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_TTL_IDX = 1'b0;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [SEQ_W-1:0]  sequence_number;
      logic [TIME_W-1:0] last_seen;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        data;
   } ram_wr_type;

endpackage

### hdl/duplicate_packet_filter.sv
// ============================================================================
// duplicate_packet_filter
// Duplicate suppression cache with a time to live per remembered entry.
// ============================================================================
// Usage:
//   A packet item (source address, sequence number, current time) is taken
//   when start is high and busy is low. The block then scans its entry
//   memory one entry per cycle, expiring entries older than ttl_us, and
//   either refreshes a matching entry (duplicate) or stores the pair in the
//   lowest free entry, else over the oldest one (new).
//   The answer appears on rsp_is_duplicate for one cycle with rsp_valid.
//   There is no back pressure on the result side.
// Timing:
//   A new packet is answered after all ENTRIES entries are scanned; a
//   duplicate is answered as soon as its entry is checked. The next item can be
//   accepted in the cycle the result is shown. The scan time is set by the
//   single read port of the entry memory, read once per entry.
// Reset:
//   Synchronous reset clears all valid bits and loads ttl_us with 5000000.
//   No clearing pass: entry contents are only looked at when valid.
// Configuration:
//   ttl_us at byte address 0 of the APB port, to be written only while idle; the block does not enforce this.
// ============================================================================
module duplicate_packet_filter
   import dpf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // packet items
   input  logic                  start,
   output logic                  busy,
   input  logic [ADDR_W-1:0]     req_source_address,
   input  logic [SEQ_W-1:0]      req_sequence_number,
   input  logic [TIME_W-1:0]     req_now_us,
   // results
   output logic                  rsp_valid,
   output logic                  rsp_is_duplicate,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type          state_ff,     state_in;
   logic [TTL_W-1:0]   ttl_ff,       ttl_in;
   logic [ENTRIES-1:0] valid_ff,     valid_in;
   logic [ADDR_W-1:0]  src_ff,       src_in;
   logic [SEQ_W-1:0]   seq_ff,       seq_in;
   logic [TIME_W-1:0]  now_ff,       now_in;
   logic [CNT_W-1:0]   cnt_ff,       cnt_in;
   logic               e1_vld_ff,    e1_vld_in;
   logic [IDX_W-1:0]   e1_idx_ff,    e1_idx_in;
   logic               e2_vld_ff,    e2_vld_in;
   logic [IDX_W-1:0]   e2_idx_ff,    e2_idx_in;
   logic [TIME_W-1:0]  e2_age_ff,    e2_age_in;
   logic               e2_match_ff,  e2_match_in;
   logic               have_free_ff, have_free_in;
   logic [IDX_W-1:0]   free_idx_ff,  free_idx_in;
   logic               have_old_ff,  have_old_in;
   logic [IDX_W-1:0]   old_idx_ff,   old_idx_in;
   logic [TIME_W-1:0]  old_age_ff,   old_age_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_dup_ff,   rsp_dup_in;

   ram_wr_type         ram_wr;
   logic [IDX_W-1:0]   ram_rd_idx;
   entry_type          ram_rd_data;
   logic               expired;
   logic               csr_write;

   dpf_entry_ram u_entry_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_idx  (ram_rd_idx),
      .rd_data (ram_rd_data)
   );

   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_TTL_IDX);
   assign expired   = e2_age_ff > {{(TIME_W - TTL_W){1'b0}}, ttl_ff};

   always_comb begin
      state_in     = state_ff;
      ttl_in       = ttl_ff;
      valid_in     = valid_ff;
      src_in       = src_ff;
      seq_in       = seq_ff;
      now_in       = now_ff;
      cnt_in       = cnt_ff;
      e1_vld_in    = 1'b0;
      e1_idx_in    = e1_idx_ff;
      have_free_in = have_free_ff;
      free_idx_in  = free_idx_ff;
      have_old_in  = have_old_ff;
      old_idx_in   = old_idx_ff;
      old_age_in   = old_age_ff;
      rsp_valid_in = 1'b0;
      rsp_dup_in   = rsp_dup_ff;
      ram_wr       = '0;
      ram_rd_idx   = cnt_ff[IDX_W-1:0];

      // first evaluation stage: age and tag compare on the read data
      e2_vld_in    = e1_vld_ff;
      e2_idx_in    = e1_idx_ff;
      e2_age_in    = now_ff - ram_rd_data.last_seen;
      e2_match_in  = (ram_rd_data.address == src_ff) &&
                     (ram_rd_data.sequence_number == seq_ff);

      if (csr_write) begin
         ttl_in = pwdata[TTL_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               src_in       = req_source_address;
               seq_in       = req_sequence_number;
               now_in       = req_now_us;
               cnt_in       = '0;
               have_free_in = 1'b0;
               have_old_in  = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff < CNT_W'(ENTRIES)) begin
               e1_vld_in = 1'b1;
               e1_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in    = cnt_ff + 1'b1;
            end
            if (e2_vld_ff) begin
               if (e2_idx_ff == IDX_W'(ENTRIES - 1)) begin
                  state_in = ST_COMMIT;
               end
               if (!valid_ff[e2_idx_ff] || expired) begin
                  valid_in[e2_idx_ff] = 1'b0;
                  if (!have_free_ff) begin
                     have_free_in = 1'b1;
                     free_idx_in  = e2_idx_ff;
                  end
               end else if (e2_match_ff) begin
                  // refresh the hit and stop the scan
                  ram_wr.en                   = 1'b1;
                  ram_wr.idx                  = e2_idx_ff;
                  ram_wr.data.address         = src_ff;
                  ram_wr.data.sequence_number = seq_ff;
                  ram_wr.data.last_seen       = now_ff;
                  rsp_valid_in = 1'b1;
                  rsp_dup_in   = 1'b1;
                  e1_vld_in    = 1'b0;
                  e2_vld_in    = 1'b0;
                  state_in     = ST_IDLE;
               end else if (!have_old_ff || (e2_age_ff > old_age_ff)) begin
                  have_old_in = 1'b1;
                  old_idx_in  = e2_idx_ff;
                  old_age_in  = e2_age_ff;
               end
            end
         end
         ST_COMMIT: begin
            ram_wr.en  = 1'b1;
            ram_wr.idx = have_free_ff ? free_idx_ff :
                         (have_old_ff ? old_idx_ff : '0);
            ram_wr.data.address         = src_ff;
            ram_wr.data.sequence_number = seq_ff;
            ram_wr.data.last_seen       = now_ff;
            valid_in[ram_wr.idx] = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_dup_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ttl_ff       <= TTL_RESET;
         valid_ff     <= '0;
         e1_vld_ff    <= 1'b0;
         e2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ttl_ff       <= ttl_in;
         valid_ff     <= valid_in;
         e1_vld_ff    <= e1_vld_in;
         e2_vld_ff    <= e2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff       <= src_in;
      seq_ff       <= seq_in;
      now_ff       <= now_in;
      cnt_ff       <= cnt_in;
      e1_idx_ff    <= e1_idx_in;
      e2_idx_ff    <= e2_idx_in;
      e2_age_ff    <= e2_age_in;
      e2_match_ff  <= e2_match_in;
      have_free_ff <= have_free_in;
      free_idx_ff  <= free_idx_in;
      have_old_ff  <= have_old_in;
      old_idx_ff   <= old_idx_in;
      old_age_ff   <= old_age_in;
      rsp_dup_ff   <= rsp_dup_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_duplicate = rsp_dup_ff;
   assign pready           = 1'b1;
   assign prdata = (paddr[2] == CSR_TTL_IDX) ?
                   {{(CSR_DATA_W - TTL_W){1'b0}}, ttl_ff} : '0;

   // an accepted item always makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start a scan");

   // a result is shown exactly when the block returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of a scan");

   a_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("scan ended without a result");

   // every entry write must be followed by a result strobe
   a_write_end: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |=> rsp_valid)
      else $error("entry write without a result");

endmodule

### hdl/dpf_entry_ram.sv
// ============================================================================
// dpf_entry_ram
// Entry store: one write port, one read port with registered read data.
// ============================================================================
module dpf_entry_ram
   import dpf_pkg::*;
(
   input  logic             clock,
   input  ram_wr_type       wr,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd_data
);

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule
